### src/tsk_pkg.sv
`timescale 1ns / 1ps
package tsk_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;
    localparam int AXES        = 3;

    localparam int PP_BITS   = SAMPLE_BITS + 1;
    localparam int DEN_BITS  = SAMPLE_BITS + 2;
    localparam int GAIN_BITS = FRAC_BITS + 1;
    localparam int CNT_BITS  = $clog2(GAIN_BITS + 1);
    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + GAIN_BITS + 1;
    localparam int VPROD_BITS = GAIN_BITS + PP_BITS;
    localparam int DATA_BITS = ((AXES * SAMPLE_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PROCESS_NOISE = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_MEASURE_NOISE = CFG_IDX_BITS'(1);

    localparam logic [SAMPLE_BITS-1:0] Q_RESET   = SAMPLE_BITS'((3 << FRAC_BITS) / 100);
    localparam logic [SAMPLE_BITS-1:0] R_RESET   = SAMPLE_BITS'((365 << FRAC_BITS) / 100);
    localparam logic [SAMPLE_BITS-1:0] VAR_RESET = SAMPLE_BITS'(1 << FRAC_BITS);
    localparam logic [GAIN_BITS-1:0]   GAIN_ONE  = GAIN_BITS'(1 << FRAC_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic seed;
        logic mul;
        logic upd;
    } t_lane_ctl;

endpackage

### src/tsk_div.sv
`timescale 1ns / 1ps
module tsk_div
    import tsk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [PP_BITS-1:0]   i_num,
    input  logic [DEN_BITS-1:0]  i_den,
    output logic                 o_done,
    output logic [GAIN_BITS-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [DEN_BITS:0]    r_part;
    logic [DEN_BITS-1:0]  r_den;
    logic [GAIN_BITS-1:0] r_q;

    logic                 w_ge;
    logic [DEN_BITS:0]    w_rem;

    always_comb begin
        w_ge  = r_part >= {1'b0, r_den};
        w_rem = w_ge ? (r_part - {1'b0, r_den}) : r_part;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(GAIN_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_part <= {2'b00, i_num};
            r_den  <= i_den;
            r_q    <= '0;
        end else if (r_busy) begin
            r_part <= {w_rem[DEN_BITS-1:0], 1'b0};
            r_q    <= {r_q[GAIN_BITS-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

### src/tsk_lane.sv
`timescale 1ns / 1ps
module tsk_lane
    import tsk_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_lane_ctl                     i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_z,
    input  logic [GAIN_BITS-1:0]          i_gain,
    output logic signed [SAMPLE_BITS-1:0] o_est
);

    logic signed [SAMPLE_BITS-1:0] r_z;
    logic signed [SAMPLE_BITS-1:0] r_est;
    logic signed [PROD_BITS-1:0]   r_prod;

    logic signed [DIFF_BITS-1:0]   w_diff;
    logic signed [GAIN_BITS:0]     w_gain;
    logic signed [PROD_BITS-1:0]   w_step;

    always_comb begin
        w_diff = DIFF_BITS'(r_z) - DIFF_BITS'(r_est);
        w_gain = {1'b0, i_gain};
        w_step = r_prod >>> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est <= '0;
        end else if (i_ctl.seed) begin
            r_est <= i_z;
        end else if (i_ctl.upd) begin
            r_est <= r_est + w_step[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_z <= i_z;
        end
        if (i_ctl.mul) begin
            r_prod <= w_diff * w_gain;
        end
    end

    assign o_est = r_est;

endmodule

### src/three_axis_scalar_kalman_unit.sv
`timescale 1ns / 1ps
// Three-axis scalar Kalman smoother. Each item carries one signed Q8.16 sample per axis
// and yields one item of filtered estimates. The first item after reset seeds the
// estimate and comes back unchanged, loaded into the output register in S_DONE. Every
// later item goes through S_PREP to start the divider, then S_DIV in the restoring divider
// that forms the shared gain P'/(P'+r) one quotient bit per cycle (17 quotient bits, then
// a done strobe), then per-axis multiplies in S_MUL, updates in S_ADD and the output
// register load in S_DONE. One item is in work at a time, so the input takes no new item
// until the last one has been loaded into the output register; a finished item waits in
// the output register while the next is accepted. Write process_noise (index 0) and
// measure_noise (index 1) only while idle.
module three_axis_scalar_kalman_unit
    import tsk_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [SAMPLE_BITS-1:0]  i_cfg_data,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // accel_x [23:0], accel_y [47:24], accel_z [71:48]
    input  logic [DATA_BITS-1:0]    s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // est_x [23:0], est_y [47:24], est_z [71:48]
    output logic [DATA_BITS-1:0]    m_axis_tdata
);

    t_state r_state;
    t_state n_state;

    logic [SAMPLE_BITS-1:0]  r_q;
    logic [SAMPLE_BITS-1:0]  r_r;
    logic [SAMPLE_BITS-1:0]  r_var;
    logic                    r_primed;
    logic [PP_BITS-1:0]      r_pp;
    logic                    r_den_zero;
    logic [GAIN_BITS-1:0]    r_gain;
    logic [VPROD_BITS-1:0]   r_vprod;
    logic                    r_out_valid;
    logic [DATA_BITS-1:0]    r_out_data;

    logic                    w_accept;
    logic                    w_out_load;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [GAIN_BITS-1:0]    w_quot;
    logic [DEN_BITS-1:0]     w_den;
    logic [VPROD_BITS-FRAC_BITS-1:0] w_vnew;
    logic [DATA_BITS-1:0]    w_pack;
    t_lane_ctl               w_ctl;
    logic signed [SAMPLE_BITS-1:0] w_z   [AXES];
    logic signed [SAMPLE_BITS-1:0] w_est [AXES];

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_den    = DEN_BITS'(r_pp) + DEN_BITS'(r_r);
    assign w_vnew   = r_vprod[VPROD_BITS-1:FRAC_BITS];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = r_primed ? S_PREP : S_DONE;
                end
            end
            S_PREP: n_state = S_DIV;
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_ADD;
            S_ADD: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_div_start   = 1'b0;
        w_out_load    = 1'b0;
        w_ctl         = '0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                w_ctl.load    = w_accept;
                w_ctl.seed    = w_accept && !r_primed;
            end
            S_PREP: w_div_start = 1'b1;
            S_MUL:  w_ctl.mul = 1'b1;
            S_ADD:  w_ctl.upd = 1'b1;
            S_DONE: w_out_load = !r_out_valid || m_axis_tready;
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_q         <= Q_RESET;
            r_r         <= R_RESET;
            r_var       <= VAR_RESET;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PROCESS_NOISE: r_q <= i_cfg_data;
                    REG_MEASURE_NOISE: r_r <= i_cfg_data;
                    default: r_q <= r_q;
                endcase
            end
            if (w_accept) begin
                r_primed <= 1'b1;
            end
            if (r_state == S_ADD) begin
                if (|w_vnew[VPROD_BITS-FRAC_BITS-1:SAMPLE_BITS]) begin
                    r_var <= '1;
                end else begin
                    r_var <= w_vnew[SAMPLE_BITS-1:0];
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pp <= PP_BITS'(r_var) + PP_BITS'(r_q);
        end
        if (w_div_start) begin
            r_den_zero <= (w_den == '0);
        end
        if (w_div_done) begin
            r_gain <= r_den_zero ? '0 : w_quot;
        end
        if (r_state == S_MUL) begin
            r_vprod <= (GAIN_ONE - r_gain) * r_pp;
        end
        if (w_out_load) begin
            r_out_data <= w_pack;
        end
    end

    tsk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_pp),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        assign w_z[g] = s_axis_tdata[g*SAMPLE_BITS +: SAMPLE_BITS];

        tsk_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_z     (w_z[g]),
            .i_gain  (r_gain),
            .o_est   (w_est[g])
        );
    end

    always_comb begin
        w_pack = '0;
        for (int i = 0; i < AXES; i++) begin
            w_pack[i*SAMPLE_BITS +: SAMPLE_BITS] = w_est[i];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
